/* src/mpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

  localparam int ARG_W     = 32;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W     = NUM_DIGITS * DIGIT_W;
  localparam int IDX_W     = $clog2(NUM_DIGITS);
  localparam int HEX_DIGITS = ARG_W / DIGIT_W;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A       = 8'h61;

  // request from the sequencer to the digit unit
  typedef struct packed {
    logic start;
    logic hex;
  } mpf_req_t;

  // ascii for one digit value, decimal or lower-case hex
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = CH_A + (dx - 8'd10);
    end
  endfunction

endpackage

`default_nettype wire

/* src/mini_printf_formatter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Minimal printf formatter: takes one format byte per input word, with a
// 32-bit argument, and sends out ASCII characters, last marking the final
// character caused by that byte. '%' arms a flag; "%d" prints the argument
// as signed decimal, "%x" as lower-case hex, both with no leading zeros;
// any other byte after '%' is printed itself and a zero byte ends the
// string. Input is taken only while the sequencer is idle. A plain
// character goes through the CHAR state before the next byte is taken;
// '%' and the zero byte are taken in the idle state alone. %d goes through
// a shared shift-and-add-3 unit, one bit per cycle; after that a minus
// sign goes out if needed, then the ten digit positions are walked from
// the top, skipping leading zeros and sending one character per digit.
// %x skips the conversion, and its nibbles are walked the same way. Each
// character sent waits for as long as the sink holds out_ready low.
module mini_printf_formatter (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire [mpf_pkg::CHAR_W-1:0]  fmt_byte,
  input  wire [mpf_pkg::ARG_W-1:0]   arg_value,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [mpf_pkg::CHAR_W-1:0] out_char,
  output logic                       last
);
  import mpf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHAR  = 3'd1;
  localparam logic [2:0] S_CONV  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DIGIT = 3'd5;

  logic [2:0]        state;
  logic              after_percent;
  logic              neg;
  logic [CHAR_W-1:0] ch;
  logic [IDX_W-1:0]  idx;
  logic              slot_free;
  logic              in_fire;
  logic              load;
  logic [CHAR_W-1:0] load_char;
  logic              load_last;
  mpf_req_t          req;
  logic [ARG_W-1:0]  mag;
  logic              dab_done;
  logic [BCD_W-1:0]  digits;
  logic [DIGIT_W-1:0] cur_digit;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign cur_digit = digits[idx*DIGIT_W +: DIGIT_W];

  // conversion request on a %d or %x completion
  always_comb begin
    req.start = in_fire && after_percent && (fmt_byte == CH_D || fmt_byte == CH_X);
    req.hex   = (fmt_byte == CH_X);
    if (fmt_byte == CH_D && arg_value[ARG_W-1]) begin
      mag = ~arg_value + 1'b1;
    end else begin
      mag = arg_value;
    end
  end

  mpf_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .mag    (mag),
    .done   (dab_done),
    .digits (digits)
  );

  // character chosen for the output register this cycle
  always_comb begin
    load      = 1'b0;
    load_char = ch;
    load_last = 1'b1;
    case (state)
      S_CHAR: begin
        load = slot_free;
      end
      S_SIGN: begin
        load      = slot_free;
        load_char = CH_MINUS;
        load_last = 1'b0;
      end
      S_DIGIT: begin
        load      = slot_free;
        load_char = digit_char(cur_digit);
        load_last = (idx == '0);
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      after_percent <= 1'b0;
      idx           <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (fmt_byte == CH_NUL) begin
              after_percent <= 1'b0;
            end else if (!after_percent && fmt_byte == CH_PERCENT) begin
              after_percent <= 1'b1;
            end else if (req.start) begin
              after_percent <= 1'b0;
              state         <= S_CONV;
            end else begin
              after_percent <= 1'b0;
              state         <= S_CHAR;
            end
          end
        end
        S_CHAR: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        S_CONV: begin
          if (dab_done) begin
            idx   <= IDX_W'(NUM_DIGITS - 1);
            state <= neg ? S_SIGN : S_SCAN;
          end
        end
        S_SIGN: begin
          if (load) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // skip leading zeros, keep at least one digit
          if (cur_digit == '0 && idx != '0) begin
            idx <= idx - 1'b1;
          end else begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (load) begin
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch  <= fmt_byte;
      neg <= (fmt_byte == CH_D) && arg_value[ARG_W-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= load_char;
      last     <= load_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) dab_done |-> state == S_CONV)
    else $error("digit unit finished outside conversion");
  assert property (@(posedge clk) disable iff (rst)
    (load && state == S_DIGIT && idx == '0) |=> state == S_IDLE)
    else $error("final digit did not return to idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DIGIT) |-> idx <= IDX_W'(NUM_DIGITS - 1))
    else $error("digit index out of range");
  assert property (@(posedge clk) disable iff (rst)
    (load && !load_last) |-> (state == S_SIGN || state == S_DIGIT))
    else $error("non-final character from a single-character item");

endmodule

`default_nettype wire

/* src/mpf_dabble.sv */
`timescale 1ns / 1ps
`default_nettype none

// digit unit: shift-and-add-3 binary to bcd, one bit per cycle;
// hex words are split into nibbles directly
module mpf_dabble (
  input  wire                      clk,
  input  wire                      rst,
  input  wire mpf_pkg::mpf_req_t   req,
  input  wire [mpf_pkg::ARG_W-1:0] mag,
  output logic                     done,
  output logic [mpf_pkg::BCD_W-1:0] digits
);
  import mpf_pkg::*;

  localparam int CNT_W = $clog2(ARG_W + 1);

  logic [ARG_W-1:0] bin;
  logic [CNT_W-1:0] cnt;
  logic [BCD_W-1:0] adj;

  // add 3 to every bcd digit of five or more
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = digits[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = digits[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // control: iteration count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.hex) begin
          cnt  <= '0;
          done <= 1'b1;
        end else begin
          cnt <= CNT_W'(ARG_W);
        end
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: load, then shift one bit into the bcd word each cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      bin <= mag;
      if (req.hex) begin
        digits <= {{(BCD_W-ARG_W){1'b0}}, mag};
      end else begin
        digits <= '0;
      end
    end else if (cnt != '0) begin
      digits <= {adj[BCD_W-2:0], bin[ARG_W-1]};
      bin    <= {bin[ARG_W-2:0], 1'b0};
    end
  end

  // a new request only arrives while the unit is quiet
  assert property (@(posedge clk) disable iff (rst) req.start |-> cnt == '0)
    else $error("digit unit restarted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> cnt == '0)
    else $error("done raised with iterations left");
  assert property (@(posedge clk) disable iff (rst)
    (req.start && !req.hex) |=> cnt == CNT_W'(ARG_W))
    else $error("decimal conversion did not load its count");

endmodule

`default_nettype wire
